// File: design/trapezoidal_setpoint_profiler_defines.svh
// Assertion macros for the trapezoidal setpoint profiler.
// Included by the port checker; needs no other file.
`ifndef TRAPEZOIDAL_SETPOINT_PROFILER_DEFINES_SVH
`define TRAPEZOIDAL_SETPOINT_PROFILER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define TSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tsp_pkg.sv
// Shared types and constants for the trapezoidal setpoint profiler.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package tsp_pkg;

    // Fixed point format and field widths
    localparam int FRACTION_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int MAG_W         = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int PROD_W        = 2 * DATA_W;

    // Divide by the tick rate of 200 = 8 * 25: shift by 3, then multiply by
    // the rounded-up reciprocal of 25. Exact for dividends below 2^30.
    localparam int TICK_PRE_SHIFT = 3;
    localparam int TICK_ODD       = 25;
    localparam int RECIP_SHIFT    = 34;
    localparam logic [DATA_W-1:0] RECIP_MUL =
        DATA_W'(((64'd1 << RECIP_SHIFT) + TICK_ODD - 1) / TICK_ODD);

    // Register values after reset
    localparam logic [MAG_W-1:0] ACCEL_RESET     = MAG_W'(64'd40 << FRACTION_BITS);
    localparam logic [MAG_W-1:0] MAX_SPEED_RESET = MAG_W'(64'd20 << FRACTION_BITS);
    localparam logic [MAG_W-1:0] END_TOL_RESET   =
        MAG_W'(((64'd1 << FRACTION_BITS) + 5) / 10);
    localparam logic [MAG_W-1:0] START_SPEED_RESET = MAG_W'(64'd5 << FRACTION_BITS);
    localparam logic [DATA_W-1:0] SOFT_UPPER_RESET = DATA_W'(64'd60 << FRACTION_BITS);
    localparam logic [DATA_W-1:0] SOFT_LOWER_RESET = '0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_RATE  = 3'd0,
        CFG_MAX_SPEED   = 3'd1,
        CFG_END_TOL     = 3'd2,
        CFG_SOFT_UPPER  = 3'd3,
        CFG_SOFT_LOWER  = 3'd4,
        CFG_START_SPEED = 3'd5
    } t_cfg_idx;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DIST,
        ST_LHS,
        ST_SQR,
        ST_DECIDE,
        ST_ACC_DIV,
        ST_VEL,
        ST_VEL_ABS,
        ST_POS_DIV,
        ST_COMMIT
    } t_state;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLAMP,
        OP_DIST,
        OP_LHS,
        OP_SQR,
        OP_DECIDE,
        OP_ACC_DIV,
        OP_VEL,
        OP_VEL_ABS,
        OP_POS_DIV,
        OP_COMMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic snap;      // setpoint lies within the end tolerance
        logic out_free;  // result register can take a new result this cycle
    } t_dp_status;

endpackage

`default_nettype wire

// File: design/tsp_ctrl.sv
// Sequencing controller of the trapezoidal setpoint profiler.
// Depends on tsp_pkg; drives the datapath through t_dp_cmd.
`default_nettype none

module tsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_goal_valid,
    output logic                o_goal_ready,
    output tsp_pkg::t_dp_cmd    o_cmd,
    input  tsp_pkg::t_dp_status i_status
);
    import tsp_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state      = r_state;
        o_goal_ready = 1'b0;
        o_cmd.op     = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_goal_ready = 1'b1;
                if (i_goal_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                o_cmd.op = OP_CLAMP;
                n_state  = ST_DIST;
            end
            ST_DIST: begin
                o_cmd.op = OP_DIST;
                n_state  = ST_LHS;
            end
            ST_LHS: begin
                // skip the profile arithmetic when the setpoint snaps
                o_cmd.op = OP_LHS;
                n_state  = i_status.snap ? ST_COMMIT : ST_SQR;
            end
            ST_SQR: begin
                o_cmd.op = OP_SQR;
                n_state  = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.op = OP_DECIDE;
                n_state  = ST_ACC_DIV;
            end
            ST_ACC_DIV: begin
                o_cmd.op = OP_ACC_DIV;
                n_state  = ST_VEL;
            end
            ST_VEL: begin
                o_cmd.op = OP_VEL;
                n_state  = ST_VEL_ABS;
            end
            ST_VEL_ABS: begin
                o_cmd.op = OP_VEL_ABS;
                n_state  = ST_POS_DIV;
            end
            ST_POS_DIV: begin
                o_cmd.op = OP_POS_DIV;
                n_state  = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the result register is free
                if (i_status.out_free) begin
                    o_cmd.op = OP_COMMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/tsp_dpath.sv
// Datapath of the trapezoidal setpoint profiler: registers, profile state,
// one shared 32x32 multiplier and the result register. Depends on tsp_pkg.
`default_nettype none

module tsp_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tsp_pkg::t_dp_cmd                      i_cmd,
    output tsp_pkg::t_dp_status                   o_status,
    input  logic signed [tsp_pkg::DATA_W-1:0]     i_goal_position,
    input  logic                                  i_cfg_we,
    input  logic        [tsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [tsp_pkg::DATA_W-1:0]     i_cfg_data,
    output logic                                  o_res_valid,
    input  logic                                  i_res_ready,
    output logic signed [tsp_pkg::DATA_W-1:0]     o_setpoint,
    output logic signed [tsp_pkg::DATA_W-1:0]     o_speed,
    output logic                                  o_slowing,
    output logic                                  o_arrived
);
    import tsp_pkg::*;

    // Saturate a 33 bit sum of two 32 bit values to the signed 32 bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] x);
        logic signed [DATA_W-1:0] res;
        if (x[DATA_W] != x[DATA_W-1]) begin
            res = x[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            res = x[DATA_W-1:0];
        end
        return res;
    endfunction

    // Magnitude of a signed 32 bit value (the most negative value maps to 2^31)
    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
        return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
    endfunction

    // Configuration registers
    logic        [MAG_W-1:0]  r_accel, r_max_speed, r_end_tol, r_start_speed;
    logic signed [DATA_W-1:0] r_soft_upper, r_soft_lower;

    // Profile state
    logic signed [DATA_W-1:0] r_target, r_pos, r_speed;

    // Working registers
    logic signed [DATA_W-1:0] r_goal, r_v0, r_vnew;
    logic        [DATA_W-1:0] r_dist, r_mag;
    logic                     r_up, r_snap, r_decel, r_acc_neg;
    logic        [MAG_W-1:0]  r_acc_mag;
    logic        [PROD_W-1:0] r_prod, r_lhs;

    // Result register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_setpoint, r_out_speed;
    logic                     r_out_slowing, r_out_arrived;

    logic                     w_up, w_snap, w_decel;
    logic        [DATA_W-1:0] w_dist, w_q;
    logic        [DATA_W-1:0] w_mul_a, w_mul_b;
    logic        [PROD_W-1:0] w_prod;
    logic signed [DATA_W:0]   w_v_ext, w_max_pos, w_max_neg, w_start_ext;
    logic signed [DATA_W:0]   w_vsum, w_psum;
    logic                     w_acc_on, w_acc_neg, w_kick;
    logic signed [DATA_W-1:0] w_v0, n_pos, n_speed;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel       <= ACCEL_RESET;
            r_max_speed   <= MAX_SPEED_RESET;
            r_end_tol     <= END_TOL_RESET;
            r_soft_upper  <= SOFT_UPPER_RESET;
            r_soft_lower  <= SOFT_LOWER_RESET;
            r_start_speed <= START_SPEED_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ACCEL_RATE:  r_accel       <= i_cfg_data[MAG_W-1:0];
                CFG_MAX_SPEED:   r_max_speed   <= i_cfg_data[MAG_W-1:0];
                CFG_END_TOL:     r_end_tol     <= i_cfg_data[MAG_W-1:0];
                CFG_SOFT_UPPER:  r_soft_upper  <= i_cfg_data;
                CFG_SOFT_LOWER:  r_soft_lower  <= i_cfg_data;
                CFG_START_SPEED: r_start_speed <= i_cfg_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    // Distance to target: compare and both differences side by side
    assign w_up   = r_pos < r_target;
    assign w_dist = w_up ? DATA_W'({r_target[DATA_W-1], r_target} - {r_pos[DATA_W-1], r_pos})
                         : DATA_W'({r_pos[DATA_W-1], r_pos} - {r_target[DATA_W-1], r_target});
    assign w_snap = r_dist < {1'b0, r_end_tol};

    // Shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.op)
            OP_LHS: begin
                w_mul_a = r_dist;
                w_mul_b = {r_accel, 1'b0};
            end
            OP_SQR: begin
                w_mul_a = r_mag;
                w_mul_b = r_mag;
            end
            OP_ACC_DIV: begin
                w_mul_a = DATA_W'(r_acc_mag >> TICK_PRE_SHIFT);
                w_mul_b = RECIP_MUL;
            end
            OP_POS_DIV: begin
                w_mul_a = r_mag >> TICK_PRE_SHIFT;
                w_mul_b = RECIP_MUL;
            end
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_q    = DATA_W'(r_prod >> RECIP_SHIFT);

    // Phase choice: braking test, acceleration sign and kick-off speed
    assign w_decel     = r_lhs < r_prod;
    assign w_v_ext     = {r_speed[DATA_W-1], r_speed};
    assign w_max_pos   = {2'b00, r_max_speed};
    assign w_max_neg   = -w_max_pos;
    assign w_start_ext = {2'b00, r_start_speed};

    always_comb begin
        w_acc_on  = 1'b0;
        w_acc_neg = 1'b0;
        if (r_up && (w_v_ext < w_max_pos)) begin
            w_acc_on = 1'b1;
        end
        if (!r_up && (w_v_ext > w_max_neg)) begin
            w_acc_on  = 1'b1;
            w_acc_neg = 1'b1;
        end
        if (w_decel) begin
            w_acc_on  = 1'b1;
            w_acc_neg = r_up;
        end
    end

    assign w_kick = (r_speed == '0) && !w_decel;
    assign w_v0   = w_kick ? (r_up ? DATA_W'(w_start_ext) : DATA_W'(-w_start_ext)) : r_speed;

    // Velocity and position updates, each one add or subtract of a tick step
    assign w_vsum = r_acc_neg ? ({r_v0[DATA_W-1], r_v0} - {1'b0, w_q})
                              : ({r_v0[DATA_W-1], r_v0} + {1'b0, w_q});
    assign w_psum = r_vnew[DATA_W-1] ? ({r_pos[DATA_W-1], r_pos} - {1'b0, w_q})
                                     : ({r_pos[DATA_W-1], r_pos} + {1'b0, w_q});
    assign n_pos   = r_snap ? r_target : sat32(w_psum);
    assign n_speed = r_snap ? '0 : r_vnew;

    // Profile state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_pos    <= '0;
            r_speed  <= '0;
        end else begin
            if (i_cmd.op == OP_CLAMP) begin
                r_target <= (r_goal < r_soft_lower) ? r_soft_lower : r_goal;
            end
            if (i_cmd.op == OP_COMMIT) begin
                r_pos   <= n_pos;
                r_speed <= n_speed;
            end
        end
    end

    // Working registers, advanced one operation per cycle except while the commit waits for the result register
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_goal <= (i_goal_position > r_soft_upper) ? r_soft_upper : i_goal_position;
            end
            OP_DIST: begin
                r_dist <= w_dist;
                r_up   <= w_up;
            end
            OP_LHS: begin
                r_prod <= w_prod;
                r_snap <= w_snap;
                r_mag  <= mag32(r_speed);
            end
            OP_SQR: begin
                r_lhs  <= r_prod;
                r_prod <= w_prod;
            end
            OP_DECIDE: begin
                r_decel   <= w_decel;
                r_acc_mag <= w_acc_on ? r_accel : '0;
                r_acc_neg <= w_acc_neg;
                r_v0      <= w_v0;
            end
            OP_ACC_DIV, OP_POS_DIV: begin
                r_prod <= w_prod;
            end
            OP_VEL: begin
                r_vnew <= sat32(w_vsum);
            end
            OP_VEL_ABS: begin
                r_mag <= mag32(r_vnew);
            end
            default: ;
        endcase
    end

    // Result register: load on commit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_COMMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_COMMIT) begin
            r_out_setpoint <= n_pos;
            r_out_speed    <= n_speed;
            r_out_slowing  <= !r_snap && r_decel;
            r_out_arrived  <= r_snap;
        end
    end

    assign o_status.snap     = w_snap;
    assign o_status.out_free = !r_out_valid || i_res_ready;

    assign o_res_valid = r_out_valid;
    assign o_setpoint  = r_out_setpoint;
    assign o_speed     = r_out_speed;
    assign o_slowing   = r_out_slowing;
    assign o_arrived   = r_out_arrived;

endmodule

`default_nettype wire

// File: design/trapezoidal_setpoint_profiler.sv
// Trapezoidal setpoint profiler: one goal position in per control tick, one
// profiled setpoint, velocity and phase flags out, in signed fixed point with
// 16 fraction bits. The goal is clamped to the soft limits, then the setpoint
// accelerates toward it up to the cruise speed, brakes once the distance is
// below v*v/(2a), kicks off at the start speed from rest and snaps to the
// target within the end tolerance. A new goal is taken only after the last
// tick has committed, and a snap skips from the braking product to commit.
// The single shared 32x32 multiplier is used in turn for the braking product,
// the velocity square and two divisions by the tick rate, with the magnitude
// and saturation steps between. A finished result waits in the output register
// while the next goal is taken. Registers are to be written through the plain
// write port only while no tick is in flight; the block does not enforce it.
// Depends on tsp_pkg, tsp_ctrl and tsp_dpath.
`default_nettype none

module trapezoidal_setpoint_profiler (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_goal_valid,
    output logic                                  o_goal_ready,
    input  logic signed [tsp_pkg::DATA_W-1:0]     i_goal_position,
    output logic                                  o_res_valid,
    input  logic                                  i_res_ready,
    output logic signed [tsp_pkg::DATA_W-1:0]     o_setpoint,
    output logic signed [tsp_pkg::DATA_W-1:0]     o_speed,
    output logic                                  o_slowing,
    output logic                                  o_arrived,
    input  logic                                  i_cfg_we,
    input  logic        [tsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [tsp_pkg::DATA_W-1:0]     i_cfg_data
);
    import tsp_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer
    tsp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_goal_valid (i_goal_valid),
        .o_goal_ready (o_goal_ready),
        .o_cmd        (w_cmd),
        .i_status     (w_status)
    );

    // Arithmetic, state and result register
    tsp_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_goal_position (i_goal_position),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_setpoint      (o_setpoint),
        .o_speed         (o_speed),
        .o_slowing       (o_slowing),
        .o_arrived       (o_arrived)
    );

endmodule

`default_nettype wire

// File: design/tsp_checker.sv
// Port-level checker for the trapezoidal setpoint profiler, bound to the top.
// Depends on trapezoidal_setpoint_profiler_defines.svh and tsp_pkg.
`default_nettype none
`include "trapezoidal_setpoint_profiler_defines.svh"

module tsp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_goal_valid,
    input logic                              o_goal_ready,
    input logic                              o_res_valid,
    input logic                              i_res_ready,
    input logic signed [tsp_pkg::DATA_W-1:0] o_setpoint,
    input logic signed [tsp_pkg::DATA_W-1:0] o_speed,
    input logic                              o_slowing,
    input logic                              o_arrived
);

    // Result stays offered until its transfer
    `TSP_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid, "result dropped before transfer")

    // Offered setpoint and speed do not change while stalled
    `TSP_ASSERT_NXT(a_res_stable, i_clk, i_rst_n, o_res_valid && !i_res_ready, $stable(o_setpoint) && $stable(o_speed), "result changed while stalled")

    // One tick at a time: no goal taken in the cycle after a transfer in
    `TSP_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_goal_valid && o_goal_ready, !o_goal_ready, "goal taken while a tick is in flight")

    // A snap is never a braking tick
    `TSP_ASSERT_IMP(a_snap_not_slowing, i_clk, i_rst_n, o_res_valid && o_arrived, !o_slowing, "snap reported with braking")

    // A snap leaves the setpoint at rest
    `TSP_ASSERT_IMP(a_snap_at_rest, i_clk, i_rst_n, o_res_valid && o_arrived, o_speed == 0, "snap with non-zero speed")

endmodule

bind trapezoidal_setpoint_profiler tsp_checker u_tsp_checker (.*);

`default_nettype wire
